// File: rtl/iorb_pkg.sv
// ----------------------------------------------------------------------------
// iorb_pkg
// Shared widths, constants and types of the in-order release buffer.
// ----------------------------------------------------------------------------
package iorb_pkg;

   localparam int SEQ_W               = 24;
   localparam int HANDLE_W            = 16;
   localparam int WINDOW_DEFAULT      = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   // releases per arriving item; further ready items wait for the next arrival
   localparam int MAX_RESULTS         = 16;

   localparam logic STATUS_RELEASED = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0]    sequence_req;
      logic [HANDLE_W-1:0] item_handle;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic             start;
      logic [SEQ_W-1:0] sequence_first;
   } restart_type;

endpackage

// File: rtl/in_order_release_buffer.sv
// ----------------------------------------------------------------------------
// in_order_release_buffer
// Reorder buffer: parks sequence-tagged items in a window of slots and
// releases them strictly in sequence order, rejecting items that fall
// outside the window or hit an occupied slot.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_sequence_req, req_item_handle
//  rsp      out        rsp_valid/rsp_ready  rsp_out_sequence, rsp_out_handle,
//                                           rsp_status, rsp_last
//  csr      in         csr_valid/csr_ready  csr_first_sequence
//
//  An item passes the input queue, is window-checked and parked, and then
//  in-order results are released (at most MAX_RESULTS). After a csr write,
//  req and csr are not ready while the slot of the first sequence number is
//  found by a reciprocal multiply; the restart lands as they open again.
//  Synchronous reset empties all slots and expects 0. A stalled rsp holds
//  draining and rejects, while items still park; the queue fills first.
// ----------------------------------------------------------------------------
module in_order_release_buffer #(
   parameter int WINDOW      = iorb_pkg::WINDOW_DEFAULT,
   parameter int QUEUE_DEPTH = iorb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [iorb_pkg::SEQ_W-1:0]    csr_first_sequence,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iorb_pkg::SEQ_W-1:0]    req_sequence_req,
   input  logic [iorb_pkg::HANDLE_W-1:0] req_item_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [iorb_pkg::SEQ_W-1:0]    rsp_out_sequence,
   output logic [iorb_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic                          rsp_status,
   output logic                          rsp_last
);

   iorb_pkg::queue_status_type q_status;
   iorb_pkg::item_type         push_item;
   iorb_pkg::item_type         head;
   iorb_pkg::restart_type      restart;
   logic [$clog2(WINDOW)-1:0]  restart_slot;
   logic                       push;
   logic                       pop;

   iorb_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_first_sequence (csr_first_sequence),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sequence_req   (req_sequence_req),
      .req_item_handle    (req_item_handle),
      .q_status           (q_status),
      .push               (push),
      .push_item          (push_item),
      .restart            (restart),
      .restart_slot       (restart_slot)
   );

   iorb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   iorb_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .restart          (restart),
      .restart_slot     (restart_slot),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sequence (rsp_out_sequence),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   // a csr write shuts both input ports while the restart is prepared
   a_csr_blocks_inputs: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready && !csr_ready)
      else $error("input accepted while restart pending");

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == iorb_pkg::STATUS_REJECTED) |-> rsp_last)
      else $error("rejected result not marked last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// File: rtl/iorb_queue.sv
// ----------------------------------------------------------------------------
// iorb_queue
// Small FIFO that carries accepted items from the front end to the back end.
// ----------------------------------------------------------------------------
module iorb_queue #(
   parameter int DEPTH = iorb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  iorb_pkg::item_type         push_item,
   input  logic                       pop,
   output iorb_pkg::item_type         head,
   output iorb_pkg::queue_status_type status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   iorb_pkg::item_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == CW'(DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

// File: rtl/iorb_front.sv
// ----------------------------------------------------------------------------
// iorb_front
// Accepts items into the queue and takes configuration writes. A write of
// the first sequence number finds its slot by a reciprocal multiply, quotient
// first and remainder second, then issues a restart to the back end.
// ----------------------------------------------------------------------------
module iorb_front #(
   parameter int WINDOW = iorb_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [iorb_pkg::SEQ_W-1:0]       csr_first_sequence,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [iorb_pkg::SEQ_W-1:0]       req_sequence_req,
   input  logic [iorb_pkg::HANDLE_W-1:0]    req_item_handle,
   input  iorb_pkg::queue_status_type       q_status,
   output logic                             push,
   output iorb_pkg::item_type               push_item,
   output iorb_pkg::restart_type            restart,
   output logic [$clog2(WINDOW)-1:0]        restart_slot
);

   localparam int SW  = $clog2(WINDOW);
   localparam int SQW = iorb_pkg::SEQ_W;
   // floor(x / WINDOW) == (x * RECIP) >> RSH for every 24-bit x
   localparam int RSH = SQW + SW;
   localparam int MW  = SQW + 1;
   localparam int PW  = SQW + MW;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic           busy_ff, busy_in;
   logic           start_ff, start_in;
   logic           step_ff, step_in;
   logic [SQW-1:0] first_ff, first_in;
   logic [SQW-1:0] quot_ff, quot_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [PW-1:0]  product;
   logic [SQW-1:0] quot_times_window;
   logic           csr_fire;

   assign csr_ready = !busy_ff;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = !busy_ff && !q_status.full;
   assign push      = req_valid && req_ready;

   assign push_item.sequence_req = req_sequence_req;
   assign push_item.item_handle  = req_item_handle;

   assign product           = PW'(first_ff) * PW'(RECIP);
   assign quot_times_window = quot_ff * SQW'(WINDOW);

   // first step: quotient; second step: remainder and restart
   always_comb begin
      busy_in  = busy_ff;
      start_in = 1'b0;
      step_in  = step_ff;
      first_in = first_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (csr_fire) begin
         busy_in  = 1'b1;
         step_in  = 1'b0;
         first_in = csr_first_sequence;
      end else if (busy_ff) begin
         if (!step_ff) begin
            step_in = 1'b1;
            quot_in = SQW'(product >> RSH);
         end else begin
            step_in  = 1'b0;
            rem_in   = SW'(first_ff - quot_times_window);
            busy_in  = 1'b0;
            start_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         start_ff <= 1'b0;
         step_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         start_ff <= start_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign restart.start          = start_ff;
   assign restart.sequence_first = first_ff;
   assign restart_slot           = rem_ff;

endmodule

// File: rtl/iorb_back.sv
// ----------------------------------------------------------------------------
// iorb_back
// Window check and slot choice for the queue head, parking into the slot
// store or rejection, and in-order draining of consecutive slots into the result register.
// ----------------------------------------------------------------------------
module iorb_back #(
   parameter int WINDOW = iorb_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iorb_pkg::restart_type         restart,
   input  logic [$clog2(WINDOW)-1:0]     restart_slot,
   input  iorb_pkg::item_type            head,
   input  iorb_pkg::queue_status_type    q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [iorb_pkg::SEQ_W-1:0]    rsp_out_sequence,
   output logic [iorb_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic                          rsp_status,
   output logic                          rsp_last
);

   localparam int SW  = $clog2(WINDOW);
   localparam int TW  = SW + 2;
   localparam int CW  = $clog2(iorb_pkg::MAX_RESULTS);
   localparam int SQW = iorb_pkg::SEQ_W;
   localparam int HW  = iorb_pkg::HANDLE_W;
   // 2^24 mod WINDOW: slot correction when an in-window number wraps past zero
   localparam int WRAP_REM = (1 << SQW) % WINDOW;

   typedef enum logic [1:0] {
      ST_CHECK = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [SQW-1:0]    exp_ff, exp_in;
   logic [SW-1:0]     exp_slot_ff, exp_slot_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [CW-1:0]     count_ff, count_in;

   logic [HW-1:0]     handle_mem [WINDOW];
   logic [HW-1:0]     rd_data_ff;
   logic              mem_we;

   logic              out_valid_ff, out_valid_in;
   logic              out_load;
   logic [SQW-1:0]    out_seq_in, out_seq_ff;
   logic [HW-1:0]     out_handle_in, out_handle_ff;
   logic              out_status_in, out_status_ff;
   logic              out_last_in, out_last_ff;

   logic [SQW-1:0]    seq_dist;
   logic              in_window;
   logic              wrap;
   logic [TW-1:0]     slot_sum;
   logic [SW-1:0]     slot;
   logic              reject;
   logic [SW-1:0]     next_slot;
   logic              out_free;
   logic              last_rel;

   assign out_free = !out_valid_ff || rsp_ready;

   // classification of the queue head against the current window
   always_comb begin
      seq_dist  = head.sequence_req - exp_ff;
      in_window = (seq_dist < SQW'(WINDOW));
      wrap      = (head.sequence_req < exp_ff);
      slot_sum  = TW'(exp_slot_ff) + TW'(seq_dist[SW-1:0]) + TW'(WINDOW)
                - (wrap ? TW'(WRAP_REM) : TW'(0));
      priority if (slot_sum >= TW'(2 * WINDOW)) begin
         slot = SW'(slot_sum - TW'(2 * WINDOW));
      end else if (slot_sum >= TW'(WINDOW)) begin
         slot = SW'(slot_sum - TW'(WINDOW));
      end else begin
         slot = SW'(slot_sum);
      end
      reject = !in_window || valid_ff[slot];
   end

   // the wrap past 2^24 can land on the slot being released
   always_comb begin
      if (exp_ff == '1) begin
         next_slot = '0;
      end else if (exp_slot_ff == SW'(WINDOW - 1)) begin
         next_slot = '0;
      end else begin
         next_slot = exp_slot_ff + 1'b1;
      end
      last_rel = (count_ff == CW'(iorb_pkg::MAX_RESULTS - 1)) || !valid_ff[next_slot]
               || (next_slot == exp_slot_ff);
   end

   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      exp_slot_in   = exp_slot_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      out_load      = 1'b0;
      out_seq_in    = head.sequence_req;
      out_handle_in = head.item_handle;
      out_status_in = iorb_pkg::STATUS_REJECTED;
      out_last_in   = 1'b1;
      out_valid_in  = out_valid_ff && !rsp_ready;
      if (restart.start) begin
         state_in    = ST_CHECK;
         exp_in      = restart.sequence_first;
         exp_slot_in = restart_slot;
         valid_in    = '0;
      end else begin
         unique case (state_ff)
            ST_CHECK: begin
               if (!q_status.empty) begin
                  if (reject) begin
                     if (out_free) begin
                        pop      = 1'b1;
                        out_load = 1'b1;
                     end
                  end else begin
                     pop            = 1'b1;
                     mem_we         = 1'b1;
                     valid_in[slot] = 1'b1;
                     count_in       = '0;
                     if (valid_ff[exp_slot_ff] || (slot == exp_slot_ff)) begin
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
            ST_DRAIN: begin
               if (out_free) begin
                  out_load              = 1'b1;
                  out_seq_in            = exp_ff;
                  out_handle_in         = rd_data_ff;
                  out_status_in         = iorb_pkg::STATUS_RELEASED;
                  out_last_in           = last_rel;
                  valid_in[exp_slot_ff] = 1'b0;
                  exp_in                = exp_ff + 1'b1;
                  exp_slot_in           = next_slot;
                  count_in              = count_ff + 1'b1;
                  if (last_rel) begin
                     state_in = ST_CHECK;
                  end
               end
            end
            default: begin
               state_in = ST_CHECK;
            end
         endcase
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CHECK;
         exp_ff       <= '0;
         exp_slot_ff  <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         exp_slot_ff  <= exp_slot_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // slot store; read port follows the next expected slot, write-first
   always_ff @(posedge clock) begin
      if (mem_we) begin
         handle_mem[slot] <= head.item_handle;
      end
      if (mem_we && (slot == exp_slot_in)) begin
         rd_data_ff <= head.item_handle;
      end else begin
         rd_data_ff <= handle_mem[exp_slot_in];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_seq_ff    <= out_seq_in;
         out_handle_ff <= out_handle_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_sequence = out_seq_ff;
   assign rsp_out_handle   = out_handle_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_last         = out_last_ff;

endmodule
